// ----- hdl/vrm_pkg.sv -----
package vrm_pkg;

  localparam int CNT_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int DIVIDEND_W = CNT_W + FRAC_W;
  localparam int CFG_IDX_W  = 2;

  // start request into the serial divider
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [CNT_W-1:0]      divisor;
  } div_req_t;

  // done pulse and quotient back from the divider
  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/vrm_div.sv -----
module vrm_div
  import vrm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [CNT_W-1:0]      div_r;
  logic [STEP_W-1:0]     cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [CNT_W:0] rem_sh;
  logic [CNT_W:0] trial;
  logic           qbit;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r, quo_r[DIVIDEND_W-1]};
    trial  = rem_sh - {1'b0, div_r};
    qbit   = ~trial[CNT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= '0;
        quo_r  <= req.dividend;
        div_r  <= req.divisor;
        cnt_r  <= STEP_W'(DIVIDEND_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= qbit ? trial[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_r <= {quo_r[DIVIDEND_W-2:0], qbit};
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- hdl/voxel_record_merge_reducer.sv -----
// Voxel record merge reducer.
// Input channel (in_*): one word per grid record of a voxel, valid/stall.
// The word flagged first seeds the accumulator; later words join it under
// the mode in the merge_mode register. The word flagged last produces one
// merged word on the output channel (out_*), also valid/stall.
// Configuration (cfg_*): write enable, index, data; write only while idle.
// Each record is accepted, then joined. In max-trust-ratio mode the
// cross products go through one shared 32x32 multiplier, then compare.
// A last record in sum mode sets up the divide, waits on the bit-serial
// divider and stores the ratio, or stores 0 if trust is not positive.
// A last record then loads the output register in the emit state; after
// that the next word is taken even while the result still waits.
// If the output register is still full and stalled, a last record holds
// there and in_stall stays high until the receiver takes the old word.
// Synchronous reset clears configuration registers, accumulator and output valid.
module voxel_record_merge_reducer
  import vrm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_first_record,
  input  logic                  in_last_record,
  input  logic [CNT_W-1:0]      in_rays_entering,
  input  logic [CNT_W-1:0]      in_rays_blocked,
  input  logic [CNT_W-1:0]      in_rays_hit,
  input  logic signed [CNT_W-1:0] in_density_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CNT_W-1:0]      out_merged_entering,
  output logic [CNT_W-1:0]      out_merged_blocked,
  output logic [CNT_W-1:0]      out_merged_hit,
  output logic signed [CNT_W-1:0] out_merged_density
);

  localparam logic [2:0] MODE_MAX_DENSITY = 3'd0;
  localparam logic [2:0] MODE_MAX_TRUST   = 3'd1;
  localparam logic [2:0] MODE_MAX_RATIO   = 3'd2;
  localparam logic [2:0] MODE_MAX_HITS    = 3'd3;
  localparam logic [2:0] MODE_SUM_RATIO   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SKIP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_THRES = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE, ST_JOIN, ST_MUL1, ST_MUL2, ST_CMP, ST_DIV_INIT, ST_DIV_WAIT, ST_EMIT
  } state_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  state_t state_r;

  logic [2:0]       mode_r;
  logic             skip_r;
  logic [CNT_W-1:0] thr_r;

  logic                    rec_first_r, rec_last_r;
  logic [CNT_W-1:0]        rec_nt_r, rec_nb_r, rec_ni_r;
  logic signed [CNT_W-1:0] rec_den_r;

  logic [CNT_W-1:0]        acc_nt_r, acc_nb_r, acc_ni_r;
  logic signed [CNT_W-1:0] acc_den_r;

  // trust ratio operands: magnitudes, denominators and signs
  logic [CNT_W-1:0]   ma_r, mb_r, mc_r, md_r;
  logic               sa_r, sc_r;
  logic [2*CNT_W-1:0] p0_r, p1_r;

  logic [CNT_W-1:0]        o_nt_r, o_nb_r, o_ni_r;
  logic signed [CNT_W-1:0] o_den_r;
  logic                    out_valid_r;

  logic signed [CNT_W:0] rec_t, acc_t, rec_a, acc_c, neg_a, neg_c;
  logic                  acc_over;
  logic [CNT_W-1:0]      mul_x, mul_y;
  logic [2*CNT_W-1:0]    mul_p;
  logic                  ratio_take;
  logic                  ratio_go;
  logic                  trust_pos;
  logic                  in_take;
  logic                  emit_go;
  state_t                post_st;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  always_comb begin
    rec_t = $signed({1'b0, rec_nt_r}) - $signed({1'b0, rec_nb_r});
    acc_t = $signed({1'b0, acc_nt_r}) - $signed({1'b0, acc_nb_r});
    rec_a = (rec_nt_r == '0) ? '0 : rec_t;
    acc_c = (acc_nt_r == '0) ? '0 : acc_t;
    neg_a = -rec_a;
    neg_c = -acc_c;
    // nonnegative trust fits in 32 bits, so compare low bits only
    acc_over  = !acc_t[CNT_W] && (acc_t[CNT_W-1:0] > thr_r);
    trust_pos = !acc_t[CNT_W] && (acc_t != '0);
  end

  // shared multiplier: |a|*d then |c|*b
  always_comb begin
    mul_x = (state_r == ST_MUL1) ? ma_r : mc_r;
    mul_y = (state_r == ST_MUL1) ? md_r : mb_r;
    mul_p = mul_x * mul_y;
  end

  always_comb begin
    ratio_take = (!sa_r && sc_r)
              || (!sa_r && !sc_r && (p0_r > p1_r))
              || (sa_r && sc_r && (p0_r < p1_r));
  end

  always_comb begin
    if (!rec_last_r) post_st = ST_IDLE;
    else if (mode_r == MODE_SUM_RATIO) post_st = ST_DIV_INIT;
    else post_st = ST_EMIT;
    // trust ratio join that needs the multiplier
    ratio_go = !rec_first_r && (mode_r == MODE_MAX_RATIO)
            && !(skip_r && (rec_den_r <= 0));
  end

  always_comb begin
    div_req.start    = (state_r == ST_DIV_INIT) && trust_pos;
    div_req.dividend = {acc_ni_r, {FRAC_W{1'b0}}};
    div_req.divisor  = acc_t[CNT_W-1:0];
  end

  vrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_take = in_valid && (state_r == ST_IDLE);
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= '0;
      skip_r      <= 1'b0;
      thr_r       <= '0;
      acc_nt_r    <= '0;
      acc_nb_r    <= '0;
      acc_ni_r    <= '0;
      acc_den_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:  mode_r <= cfg_wdata[2:0];
          REG_SKIP:  skip_r <= cfg_wdata[0];
          REG_THRES: thr_r  <= cfg_wdata;
          default:   ;
        endcase
      end

      if (emit_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            rec_first_r <= in_first_record;
            rec_last_r  <= in_last_record;
            rec_nt_r    <= in_rays_entering;
            rec_nb_r    <= in_rays_blocked;
            rec_ni_r    <= in_rays_hit;
            rec_den_r   <= in_density_in;
            state_r     <= ST_JOIN;
          end
        end
        ST_JOIN: begin
          state_r <= ratio_go ? ST_MUL1 : post_st;
          if (rec_first_r) begin
            acc_nt_r  <= rec_nt_r;
            acc_nb_r  <= rec_nb_r;
            acc_ni_r  <= rec_ni_r;
            acc_den_r <= rec_den_r;
          end else begin
            case (mode_r)
              MODE_MAX_DENSITY: begin
                if (rec_den_r > acc_den_r) begin
                  acc_nt_r  <= rec_nt_r;
                  acc_nb_r  <= rec_nb_r;
                  acc_ni_r  <= rec_ni_r;
                  acc_den_r <= rec_den_r;
                end
              end
              MODE_MAX_TRUST: begin
                if (rec_t > acc_t) begin
                  acc_nt_r  <= rec_nt_r;
                  acc_nb_r  <= rec_nb_r;
                  acc_ni_r  <= rec_ni_r;
                  acc_den_r <= rec_den_r;
                end
              end
              MODE_MAX_RATIO: begin
                if (ratio_go) begin
                  sa_r    <= rec_a[CNT_W];
                  sc_r    <= acc_c[CNT_W];
                  ma_r    <= rec_a[CNT_W] ? neg_a[CNT_W-1:0] : rec_a[CNT_W-1:0];
                  mc_r    <= acc_c[CNT_W] ? neg_c[CNT_W-1:0] : acc_c[CNT_W-1:0];
                  mb_r    <= (rec_nt_r == '0) ? CNT_W'(1) : rec_nt_r;
                  md_r    <= (acc_nt_r == '0) ? CNT_W'(1) : acc_nt_r;
                end
              end
              MODE_MAX_HITS: begin
                if (rec_ni_r > acc_ni_r) begin
                  acc_nt_r  <= rec_nt_r;
                  acc_nb_r  <= rec_nb_r;
                  acc_ni_r  <= rec_ni_r;
                  acc_den_r <= rec_den_r;
                end
              end
              MODE_SUM_RATIO: begin
                if (acc_over) begin
                  acc_nt_r <= sat_add(acc_nt_r, rec_nt_r);
                  acc_nb_r <= sat_add(acc_nb_r, rec_nb_r);
                  acc_ni_r <= sat_add(acc_ni_r, rec_ni_r);
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL1: begin
          p0_r    <= mul_p;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          p1_r    <= mul_p;
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (ratio_take) begin
            acc_nt_r  <= rec_nt_r;
            acc_nb_r  <= rec_nb_r;
            acc_ni_r  <= rec_ni_r;
            acc_den_r <= rec_den_r;
          end
          state_r <= post_st;
        end
        ST_DIV_INIT: begin
          if (trust_pos) begin
            state_r <= ST_DIV_WAIT;
          end else begin
            acc_den_r <= '0;
            state_r   <= ST_EMIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            // clamp to the largest positive Q16.16 value
            if (|div_rsp.quotient[DIVIDEND_W-1:CNT_W-1])
              acc_den_r <= $signed({1'b0, {(CNT_W-1){1'b1}}});
            else
              acc_den_r <= $signed(div_rsp.quotient[CNT_W-1:0]);
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            o_nt_r      <= acc_nt_r;
            o_nb_r      <= acc_nb_r;
            o_ni_r      <= acc_ni_r;
            o_den_r     <= acc_den_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_merged_entering = o_nt_r;
  assign out_merged_blocked  = o_nb_r;
  assign out_merged_hit      = o_ni_r;
  assign out_merged_density  = o_den_r;

endmodule

// ----- tb/voxel_record_merge_reducer_tb.sv -----
module voxel_record_merge_reducer_tb;
  import vrm_pkg::*;

  typedef enum logic [2:0] {
    MODE_MAX_DENSITY = 3'd0,
    MODE_MAX_TRUST   = 3'd1,
    MODE_MAX_RATIO   = 3'd2,
    MODE_MAX_HITS    = 3'd3,
    MODE_SUM_RATIO   = 3'd4,
    MODE_RSVD5       = 3'd5,
    MODE_RSVD6       = 3'd6,
    MODE_RSVD7       = 3'd7
  } merge_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MERGE_MODE        = 2'd0,
    REG_SKIP_ZERO_DENSITY = 2'd1,
    REG_TRUST_THRESHOLD   = 2'd2,
    REG_SPARE             = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                    is_first;
    logic                    is_last;
    logic [CNT_W-1:0]        nt;
    logic [CNT_W-1:0]        nb;
    logic [CNT_W-1:0]        ni;
    logic signed [CNT_W-1:0] density;
  } record_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]        nt;
    logic [CNT_W-1:0]        nb;
    logic [CNT_W-1:0]        ni;
    logic signed [CNT_W-1:0] density;
  } merged_word_t;

  localparam int          CONFIG_GAP = 80;
  localparam int          END_GAP    = 120;
  localparam int          RX_HOLD    = 600;
  localparam int unsigned RUN_LIMIT  = 5_000_000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CNT_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_first_record = 1'b0;
  logic                    in_last_record = 1'b0;
  logic [CNT_W-1:0]        in_rays_entering = '0;
  logic [CNT_W-1:0]        in_rays_blocked = '0;
  logic [CNT_W-1:0]        in_rays_hit = '0;
  logic signed [CNT_W-1:0] in_density_in = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CNT_W-1:0]        out_merged_entering;
  logic [CNT_W-1:0]        out_merged_blocked;
  logic [CNT_W-1:0]        out_merged_hit;
  logic signed [CNT_W-1:0] out_merged_density;

  // predictor configuration and accumulator
  merge_mode_e             merge_sel = MODE_MAX_DENSITY;
  logic                    skip_nonpos = 1'b0;
  logic [CNT_W-1:0]        trust_floor = '0;
  logic [CNT_W-1:0]        held_nt = '0;
  logic [CNT_W-1:0]        held_nb = '0;
  logic [CNT_W-1:0]        held_ni = '0;
  logic signed [CNT_W-1:0] held_density = '0;

  record_word_t records_to_send[$];
  merged_word_t merged_due[$];
  int           records_queued = 0;
  int           fail_cnt = 0;
  int           tx_idle_pct = 19;
  int           rx_idle_pct = 19;
  int           rx_hold_req = 0;
  int           hold_left = 0;
  bit           word_taken = 1'b0;

  voxel_record_merge_reducer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_first_record     (in_first_record),
    .in_last_record      (in_last_record),
    .in_rays_entering    (in_rays_entering),
    .in_rays_blocked     (in_rays_blocked),
    .in_rays_hit         (in_rays_hit),
    .in_density_in       (in_density_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_merged_entering (out_merged_entering),
    .out_merged_blocked  (out_merged_blocked),
    .out_merged_hit      (out_merged_hit),
    .out_merged_density  (out_merged_density)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint trust_of(input logic [CNT_W-1:0] nt, input logic [CNT_W-1:0] nb);
    return longint'({32'd0, nt}) - longint'({32'd0, nb});
  endfunction

  function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // (nt-nb)/nt of the new word strictly above that of the held one; nt of 0 means ratio 0
  function automatic bit ratio_beats(input logic [CNT_W-1:0] new_nt,
                                     input logic [CNT_W-1:0] new_nb,
                                     input logic [CNT_W-1:0] old_nt,
                                     input logic [CNT_W-1:0] old_nb);
    longint      a, c;
    logic [63:0] b, d, ma, mc;
    a = 0;
    c = 0;
    b = 64'd1;
    d = 64'd1;
    if (new_nt != '0) begin
      a = trust_of(new_nt, new_nb);
      b = {32'd0, new_nt};
    end
    if (old_nt != '0) begin
      c = trust_of(old_nt, old_nb);
      d = {32'd0, old_nt};
    end
    if (a >= 0 && c < 0) return 1'b1;
    if (a < 0 && c >= 0) return 1'b0;
    if (a >= 0) begin
      ma = a;
      mc = c;
      return ma * d > mc * b;
    end
    ma = -a;
    mc = -c;
    return ma * d < mc * b;
  endfunction

  function automatic void merge_record(input record_word_t rec);
    longint       t;
    logic [63:0]  num, den, quo;
    merged_word_t res;
    bit           adopt;
    adopt = 1'b0;
    if (rec.is_first) begin
      adopt = 1'b1;
    end else begin
      case (merge_sel)
        MODE_MAX_DENSITY: adopt = rec.density > held_density;
        MODE_MAX_TRUST:   adopt = trust_of(rec.nt, rec.nb) > trust_of(held_nt, held_nb);
        MODE_MAX_RATIO:   adopt = !(skip_nonpos && rec.density <= 0) &&
                                  ratio_beats(rec.nt, rec.nb, held_nt, held_nb);
        MODE_MAX_HITS:    adopt = rec.ni > held_ni;
        MODE_SUM_RATIO: begin
          if (trust_of(held_nt, held_nb) > longint'({32'd0, trust_floor})) begin
            held_nt = sat_sum(held_nt, rec.nt);
            held_nb = sat_sum(held_nb, rec.nb);
            held_ni = sat_sum(held_ni, rec.ni);
          end
        end
        default: ;
      endcase
    end
    if (adopt) begin
      held_nt      = rec.nt;
      held_nb      = rec.nb;
      held_ni      = rec.ni;
      held_density = rec.density;
    end
    if (!rec.is_last) return;
    if (merge_sel == MODE_SUM_RATIO) begin
      t = trust_of(held_nt, held_nb);
      held_density = '0;
      if (t > 0) begin
        num = {16'd0, held_ni, 16'd0};
        den = t;
        quo = num / den;
        held_density = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[CNT_W-1:0];
      end
    end
    res.nt      = held_nt;
    res.nb      = held_nb;
    res.ni      = held_ni;
    res.density = held_density;
    merged_due.push_back(res);
  endfunction

  function automatic void note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endfunction

  // accept, predict, check
  always @(posedge clk) begin
    record_word_t rec;
    merged_word_t got, want;
    if (rst_n && in_valid && !in_stall) begin
      rec.is_first = in_first_record;
      rec.is_last  = in_last_record;
      rec.nt       = in_rays_entering;
      rec.nb       = in_rays_blocked;
      rec.ni       = in_rays_hit;
      rec.density  = in_density_in;
      merge_record(rec);
      word_taken = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      got.nt      = out_merged_entering;
      got.nb      = out_merged_blocked;
      got.ni      = out_merged_hit;
      got.density = out_merged_density;
      if (merged_due.size() == 0) begin
        note_fail($sformatf("unexpected merged word nt=%h nb=%h ni=%h density=%h",
                            got.nt, got.nb, got.ni, got.density));
      end else begin
        want = merged_due.pop_front();
        if (got.nt !== want.nt || got.nb !== want.nb || got.ni !== want.ni ||
            got.density !== want.density) begin
          note_fail($sformatf("merged word mismatch: exp nt=%h nb=%h ni=%h density=%h",
                              want.nt, want.nb, want.ni, want.density));
          if (fail_cnt <= 10)
            $display("                       got nt=%h nb=%h ni=%h density=%h",
                     got.nt, got.nb, got.ni, got.density);
        end
      end
    end
  end

  always @(negedge clk) begin
    record_word_t rec;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (records_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        rec = records_to_send.pop_front();
        in_valid         <= 1'b1;
        in_first_record  <= rec.is_first;
        in_last_record   <= rec.is_last;
        in_rays_entering <= rec.nt;
        in_rays_blocked  <= rec.nb;
        in_rays_hit      <= rec.ni;
        in_density_in    <= rec.density;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold_req != 0) begin
      hold_left   = rx_hold_req;
      rx_hold_req = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(16);
      5, 6:    return $urandom_range(100000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_blocked(input logic [CNT_W-1:0] nt);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return (nt == '0) ? '0 : $urandom_range(nt);
      6:                return nt;
      default:          return pick_count();
    endcase
  endfunction

  function automatic logic signed [CNT_W-1:0] pick_density();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000;
      3, 4, 5: return $urandom_range(64) - 32;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_fixed(input logic is_first, input logic is_last,
                             input logic [CNT_W-1:0] nt, input logic [CNT_W-1:0] nb,
                             input logic [CNT_W-1:0] ni, input logic signed [CNT_W-1:0] density);
    record_word_t rec;
    rec.is_first = is_first;
    rec.is_last  = is_last;
    rec.nt       = nt;
    rec.nb       = nb;
    rec.ni       = ni;
    rec.density  = density;
    records_to_send.push_back(rec);
    records_queued++;
  endtask

  task automatic queue_record(input logic is_first, input logic is_last);
    logic [CNT_W-1:0] nt;
    nt = pick_count();
    queue_fixed(is_first, is_last, nt, pick_blocked(nt), pick_count(), pick_density());
  endtask

  // mostly whole voxels (first .. last), some stray words
  task automatic queue_random(input int count);
    int start, n;
    start = records_queued;
    while (records_queued - start < count) begin
      if ($urandom_range(99) < 80) begin
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++) queue_record(i == 0, i == n - 1);
      end else begin
        queue_record(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic drain(input int extra);
    do @(posedge clk);
    while (records_to_send.size() != 0 || in_valid || merged_due.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CNT_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_MERGE_MODE:        merge_sel = merge_mode_e'(data[2:0]);
      REG_SKIP_ZERO_DENSITY: skip_nonpos = data[0];
      REG_TRUST_THRESHOLD:   trust_floor = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // junk in the upper data bits must be dropped by the narrow registers
  task automatic set_config(input merge_mode_e mode, input logic skip,
                            input logic [CNT_W-1:0] thresh);
    drain(CONFIG_GAP);
    write_reg(REG_MERGE_MODE, {29'($urandom()), mode});
    write_reg(REG_SKIP_ZERO_DENSITY, {31'($urandom()), skip});
    write_reg(REG_TRUST_THRESHOLD, thresh);
  endtask

  task automatic random_phase(input merge_mode_e mode, input logic skip,
                              input logic [CNT_W-1:0] thresh, input int count);
    set_config(mode, skip, thresh);
    queue_random(count);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: max density
    queue_fixed(1'b0, 1'b1, 32'd7, 32'd2, 32'd3, 32'sd5);  // joins the reset zeros
    queue_fixed(1'b1, 1'b1, '1, '0, '1, 32'sh8000_0000);
    queue_fixed(1'b1, 1'b0, '0, '0, '0, 32'sh7FFF_FFFF);
    queue_fixed(1'b0, 1'b1, 32'd9, 32'd1, 32'd1, 32'sh7FFF_FFFF);  // tie keeps seed

    set_config(MODE_MAX_TRUST, 1'b0, '0);
    queue_fixed(1'b1, 1'b0, 32'd3, 32'd10, 32'd1, 32'sd1);  // negative trust
    queue_fixed(1'b0, 1'b0, 32'd5, 32'd4, 32'd2, 32'sd2);
    queue_fixed(1'b0, 1'b1, '1, 32'hFFFF_FFFE, 32'd3, 32'sd3);

    set_config(MODE_MAX_RATIO, 1'b1, '0);
    queue_fixed(1'b1, 1'b0, '0, '0, 32'd1, 32'sd1);  // nt zero: ratio zero
    queue_fixed(1'b0, 1'b0, 32'd10, '0, 32'd2, '0);  // best ratio, density zero
    queue_fixed(1'b0, 1'b0, 32'd10, 32'd20, 32'd3, 32'sd5);
    queue_fixed(1'b0, 1'b0, 32'd3, 32'd1, 32'd4, 32'sd7);
    queue_fixed(1'b0, 1'b1, 32'd6, 32'd2, 32'd5, 32'sd9);  // equal ratio

    set_config(MODE_MAX_HITS, 1'b0, '0);
    queue_fixed(1'b1, 1'b0, 32'd4, 32'd1, 32'd5, 32'sd1);
    queue_fixed(1'b0, 1'b0, 32'd8, 32'd2, 32'd5, 32'sd2);
    queue_fixed(1'b0, 1'b1, 32'd2, 32'd2, '1, -32'sd3);

    set_config(MODE_SUM_RATIO, 1'b0, '0);
    queue_fixed(1'b1, 1'b0, '1, '0, '1, '0);
    queue_fixed(1'b0, 1'b1, 32'd5, '0, 32'd5, '0);  // saturating sums
    queue_fixed(1'b1, 1'b1, 32'd1, '0, '1, '0);     // ratio clips
    queue_fixed(1'b1, 1'b1, 32'd2, 32'd5, 32'd1, 32'sd4);
    queue_fixed(1'b1, 1'b0, 32'd3, 32'd3, 32'd1, '0);  // trust at threshold
    queue_fixed(1'b0, 1'b1, 32'd100, '0, 32'd1, '0);

    set_config(MODE_RSVD7, 1'b1, '1);
    write_reg(REG_SPARE, $urandom());
    queue_fixed(1'b1, 1'b0, 32'd6, 32'd1, 32'd2, 32'sd3);
    queue_fixed(1'b0, 1'b1, '1, '0, '1, 32'sh7FFF_FFFF);

    random_phase(MODE_MAX_DENSITY, 1'b0, '0, 125);
    random_phase(MODE_MAX_TRUST, 1'b1, $urandom(), 125);
    random_phase(MODE_MAX_RATIO, 1'b0, '0, 125);
    random_phase(MODE_MAX_RATIO, 1'b1, '1, 125);
    random_phase(MODE_MAX_HITS, 1'b0, '0, 125);

    // receiver holds off while words keep coming, so the block backs up
    set_config(MODE_SUM_RATIO, 1'b0, '0);
    rx_hold_req = RX_HOLD;
    queue_random(125);

    random_phase(MODE_SUM_RATIO, 1'b1, 32'd50, 125);
    random_phase(MODE_SUM_RATIO, 1'b0, '1, 100);

    // sender stops mid-phase until all merged words are back
    set_config(MODE_SUM_RATIO, 1'b0, $urandom_range(1000));
    queue_random(60);
    drain(0);
    queue_random(65);

    drain(CONFIG_GAP);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(MODE_MAX_DENSITY, 1'b1, '0, 125);
    drain(CONFIG_GAP);
    tx_idle_pct = 19;
    rx_idle_pct = 19;

    random_phase(MODE_RSVD5, 1'b0, '0, 40);
    random_phase(MODE_MAX_TRUST, 1'b0, 32'd100000, 125);

    drain(END_GAP);
    if (fail_cnt == 0 && merged_due.size() == 0) begin
      $display("voxel_record_merge_reducer regression: pass");
    end else begin
      $display("voxel_record_merge_reducer regression: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("voxel_record_merge_reducer regression: fail");
    $finish;
  end

endmodule
